[rtl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is asserted
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Clocked next-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/spq_pkg.sv]
// Shared types and constants of the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic                      push;
    logic                      pop;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/sorted_priority_queue_unit.sv]
// Top level of the sorted max-priority queue built from a row of cells
`default_nettype none

// Sorted max-priority queue of DEPTH signed 32-bit entries, largest first,
// equal values leaving in arrival order. busy is always low: a push or pop
// request is accepted in every cycle that start is high, and its one result
// appears on the out_ ports for exactly one cycle, marked by out_valid, in the
// cycle right after acceptance. The receiver cannot stall; sample the result
// while out_valid is high. Each request is handled by the single
// compare-and-shift step that every cell of the row performs in parallel.
// A push into a full queue or a pop from an empty one leaves the contents as
// they are and raises out_op_error. out_entry_count carries the low five bits
// of the stored count.
module sorted_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_op,
  input  wire logic signed [spq_pkg::VALUE_W-1:0]  in_value,
  output logic                                     out_valid,
  output logic signed [spq_pkg::VALUE_W-1:0]       out_front_value,
  output logic [spq_pkg::COUNT_OUT_W-1:0]          out_entry_count,
  output logic                                     out_is_empty,
  output logic                                     out_is_full,
  output logic                                     out_op_error
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [spq_pkg::VALUE_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]                   valid;
  logic [DEPTH-1:0]                   lt;

  spq_pkg::cell_ctrl_t ctrl;
  logic                full, empty, push_ok, pop_ok, err;
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, op_error_r;
  logic [CW+spq_pkg::COUNT_OUT_W-1:0] count_ext;

  assign busy  = 1'b0;
  assign full  = valid[DEPTH-1];
  assign empty = !valid[0];

  assign push_ok = start && (in_op == spq_pkg::OP_PUSH) && !full;
  assign pop_ok  = start && (in_op == spq_pkg::OP_POP) && !empty;
  assign err     = start && !push_ok && !pop_ok;

  assign ctrl.push  = push_ok;
  assign ctrl.pop   = pop_ok;
  assign ctrl.value = in_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [spq_pkg::VALUE_W-1:0] p_entry, n_entry;
    logic                               p_valid, p_lt, n_valid;

    if (i == 0) begin : g_head
      // head has no predecessor: insert here whenever this slot is smaller
      assign p_entry = '0;
      assign p_valid = 1'b1;
      assign p_lt    = 1'b0;
    end else begin : g_mid
      assign p_entry = entry[i-1];
      assign p_valid = valid[i-1];
      assign p_lt    = lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_entry = '0;
      assign n_valid = 1'b0;
    end else begin : g_body
      assign n_entry = entry[i+1];
      assign n_valid = valid[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_entry (p_entry),
      .prev_valid (p_valid),
      .prev_lt    (p_lt),
      .next_entry (n_entry),
      .next_valid (n_valid),
      .entry      (entry[i]),
      .valid      (valid[i]),
      .lt         (lt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      op_error_r  <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= start;
      op_error_r  <= err;
    end
  end

  assign count_ext = {{spq_pkg::COUNT_OUT_W{1'b0}}, count_r};

  // Results read from the registered cell row and count register in the cycle after the request
  assign out_valid       = out_valid_r;
  assign out_front_value = valid[0] ? entry[0] : '0;
  assign out_entry_count = count_ext[spq_pkg::COUNT_OUT_W-1:0];
  assign out_is_empty    = empty;
  assign out_is_full     = full;
  assign out_op_error    = op_error_r;

endmodule

`default_nettype wire

[rtl/spq_cell.sv]
// One slot of the sorted row: compare against the broadcast value and shift
`default_nettype none

module spq_cell (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire spq_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] prev_entry,
  input  wire logic                              prev_valid,
  input  wire logic                              prev_lt,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] next_entry,
  input  wire logic                              next_valid,
  output logic signed [spq_pkg::VALUE_W-1:0]     entry,
  output logic                                   valid,
  output logic                                   lt
);

  logic signed [spq_pkg::VALUE_W-1:0] entry_r, entry_nxt;
  logic                               valid_r, valid_nxt;

  // An empty slot counts as smaller than anything
  assign lt = !valid_r || (entry_r < ctrl.value);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctrl.push) begin
      if (lt) begin
        // take the new value at the insert point, else shift down from the neighbor
        entry_nxt = prev_lt ? prev_entry : ctrl.value;
        valid_nxt = valid_r | prev_valid;
      end
    end else if (ctrl.pop) begin
      entry_nxt = next_entry;
      valid_nxt = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

[rtl/spq_checker.sv]
// Port-level checks of the sorted priority queue and their binding
`default_nettype none

`include "assert_macros.svh"

module spq_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                in_op,
  input wire logic                                out_valid,
  input wire logic signed [spq_pkg::VALUE_W-1:0]  out_front_value,
  input wire logic [spq_pkg::COUNT_OUT_W-1:0]     out_entry_count,
  input wire logic                                out_is_empty,
  input wire logic                                out_is_full,
  input wire logic                                out_op_error
);

  `SPQ_ASSERT_NXT(a_result_follows, clk, rst_n, start && !busy, out_valid)
  `SPQ_ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, $past(start && !busy))
  `SPQ_ASSERT_IMP(a_empty_shape, clk, rst_n, out_valid && out_is_empty,
                  out_entry_count == '0 && out_front_value == '0 && !out_is_full)
  `SPQ_ASSERT_IMP(a_pop_err, clk, rst_n,
                  out_valid && out_op_error && $past(in_op) == spq_pkg::OP_POP,
                  out_is_empty)
  `SPQ_ASSERT_IMP(a_push_err, clk, rst_n,
                  out_valid && out_op_error && $past(in_op) == spq_pkg::OP_PUSH,
                  out_is_full)

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_front_value (out_front_value),
  .out_entry_count (out_entry_count),
  .out_is_empty    (out_is_empty),
  .out_is_full     (out_is_full),
  .out_op_error    (out_op_error)
);

`default_nettype wire
